// ===== hdl/rrts_pkg.sv =====
// Shared types, codes and constants of the round-robin task scheduler.
package rrts_pkg;

   localparam int TASK_SLOTS_DEFAULT = 64;

   localparam int REQ_TYPE_W = 2;
   localparam int TASK_ID_W  = 6;
   localparam int SLICE_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_ST_W  = 2;

   localparam logic [SLICE_W-1:0] INIT_SLICE_RESET = 16'd2;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RUN   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SLEEP = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   // Slot states as kept in the status memory.
   localparam logic [SLOT_ST_W-1:0] SLOT_FREE  = 2'd0;
   localparam logic [SLOT_ST_W-1:0] SLOT_ALLOC = 2'd1;
   localparam logic [SLOT_ST_W-1:0] SLOT_RUN   = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_RUN_RD,
      S_RUN_EXEC,
      S_TICK,
      S_TICK_LIST,
      S_TICK_SLICE,
      S_TICK_OUT,
      S_SLP_RD,
      S_SLP_CHK,
      S_SLP_CUR,
      S_SLP_FIND,
      S_SLP_SHIFT,
      S_SLP_FIX,
      S_SLP_LAST,
      S_SLP_OUT,
      S_DONE
   } state_type;

endpackage

// ===== hdl/rrts_if.sv =====
// Request and response channel interfaces of the task scheduler.
interface rrts_req_if;
   logic                              valid;
   logic                              ready;
   logic [rrts_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [rrts_pkg::TASK_ID_W-1:0]    task_id;
   logic [rrts_pkg::SLICE_W-1:0]      slice_ticks;

   modport source (output valid, req_type, task_id, slice_ticks, input ready);
   modport sink   (input valid, req_type, task_id, slice_ticks, output ready);
endinterface

interface rrts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rrts_pkg::STATUS_W-1:0]     status;
   logic [rrts_pkg::TASK_ID_W-1:0]    result_task;
   logic [rrts_pkg::SLICE_W-1:0]      timer_reload;
   logic                              do_switch;

   modport source (output valid, status, result_task, timer_reload, do_switch,
                   input ready);
   modport sink   (input valid, status, result_task, timer_reload, do_switch,
                   output ready);
endinterface

// ===== hdl/rrts_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler: sequencer, state registers and memories.
//
// Requests arrive as beats on the req channel (allocate, run, sleep, tick) and
// every request gives exactly one response beat on the rsp channel. Slot state,
// slot slices and the run list sit in three RAMs of one write and one read port
// each, which one small sequencer walks, one entry per cycle. A request is taken
// only while the sequencer is idle. Allocate searches for the first free slot;
// sleep searches and compacts the run list through its one read and one write
// port. The sequencer returns to idle as the response is registered.
// The slice of the first task lives in a register that the csr write port
// loads at any time.
// After reset a clearing pass writes every slot of the status and slice RAMs,
// one per cycle, so req.ready stays low until the pass is through.
// The response sits in an output register: a stalled receiver holds it there
// while the next request is already taken and served; a further response then
// waits until the held beat is taken.
module round_robin_task_scheduler #(
   parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   rrts_req_if.sink                      req,
   rrts_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(TASK_SLOTS);
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam int IW = $clog2(TASK_SLOTS + 2);

   rrts_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                    scan_ff, scan_in;
   logic [IW-1:0]                    prev_ff, prev_in;
   logic [IW-1:0]                    pos_ff, pos_in;
   logic                             chk_ff, chk_in;
   logic [CW-1:0]                    rc_ff, rc_in;
   logic [AW-1:0]                    ci_ff, ci_in;
   logic [rrts_pkg::SLICE_W-1:0]     slice0_ff, slice0_in;
   logic [rrts_pkg::TASK_ID_W-1:0]   id_ff, id_in;
   logic [rrts_pkg::SLICE_W-1:0]     slice_ff, slice_in;
   logic                             was_ff, was_in;
   logic [AW-1:0]                    tmp_ff, tmp_in;
   logic [rrts_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [rrts_pkg::TASK_ID_W-1:0]   res_task_ff, res_task_in;
   logic [rrts_pkg::SLICE_W-1:0]     res_reload_ff, res_reload_in;
   logic                             res_switch_ff, res_switch_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [rrts_pkg::TASK_ID_W-1:0]   rsp_task_ff, rsp_task_in;
   logic [rrts_pkg::SLICE_W-1:0]     rsp_reload_ff, rsp_reload_in;
   logic                             rsp_switch_ff, rsp_switch_in;

   // Memory ports.
   logic                             st_wr_en;
   logic [AW-1:0]                    st_wr_addr;
   logic [rrts_pkg::SLOT_ST_W-1:0]   st_wr_data;
   logic [AW-1:0]                    st_rd_addr;
   logic [rrts_pkg::SLOT_ST_W-1:0]   st_rd;
   logic                             sl_wr_en;
   logic [AW-1:0]                    sl_wr_addr;
   logic [rrts_pkg::SLICE_W-1:0]     sl_wr_data;
   logic [AW-1:0]                    sl_rd_addr;
   logic [rrts_pkg::SLICE_W-1:0]     sl_rd;
   logic                             ls_wr_en;
   logic [AW-1:0]                    ls_wr_addr;
   logic [AW-1:0]                    ls_wr_data;
   logic [AW-1:0]                    ls_rd_addr;
   logic [AW-1:0]                    ls_rd;

   // Shared conditions.
   logic          req_fire;
   logic          rsp_free;
   logic          in_id_ok;
   logic [AW-1:0] slot_id;
   logic [IW-1:0] rc_ext;
   logic          alloc_hit;
   logic          alloc_end;
   logic          slp_refuse;
   logic          find_hit;
   logic          shift_more;
   logic [IW-1:0] ci_inc;
   logic [AW-1:0] ci_adj;
   logic [CW-1:0] rc_dec;

   assign req_fire   = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign in_id_ok   = 32'(req.task_id) < 32'(TASK_SLOTS);
   assign slot_id    = AW'(id_ff);
   assign rc_ext     = IW'(rc_ff);
   assign alloc_hit  = chk_ff && (st_rd == rrts_pkg::SLOT_FREE);
   assign alloc_end  = chk_ff && (prev_ff == IW'(TASK_SLOTS - 1));
   assign slp_refuse = (st_rd != rrts_pkg::SLOT_RUN) || (rc_ff <= CW'(1));
   assign find_hit   = chk_ff && (ls_rd == slot_id);
   assign shift_more = (prev_ff + IW'(1)) < rc_ext;
   assign ci_inc     = IW'(ci_ff) + IW'(1);
   assign ci_adj     = (pos_ff < IW'(ci_ff)) ? (ci_ff - AW'(1)) : ci_ff;
   assign rc_dec     = rc_ff - CW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::S_CLEAR: begin
            if (scan_ff == IW'(TASK_SLOTS - 1)) begin
               state_in = rrts_pkg::S_IDLE;
            end
         end
         rrts_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req.req_type)
                  rrts_pkg::REQ_ALLOC: state_in = rrts_pkg::S_ALLOC;
                  rrts_pkg::REQ_TICK:  state_in = rrts_pkg::S_TICK;
                  rrts_pkg::REQ_RUN: begin
                     state_in = in_id_ok ? rrts_pkg::S_RUN_RD : rrts_pkg::S_DONE;
                  end
                  default: begin
                     state_in = in_id_ok ? rrts_pkg::S_SLP_RD : rrts_pkg::S_DONE;
                  end
               endcase
            end
         end
         rrts_pkg::S_ALLOC: begin
            if (alloc_hit || alloc_end) begin
               state_in = rrts_pkg::S_DONE;
            end
         end
         rrts_pkg::S_RUN_RD:     state_in = rrts_pkg::S_RUN_EXEC;
         rrts_pkg::S_RUN_EXEC:   state_in = rrts_pkg::S_DONE;
         rrts_pkg::S_TICK:       state_in = rrts_pkg::S_TICK_LIST;
         rrts_pkg::S_TICK_LIST:  state_in = rrts_pkg::S_TICK_SLICE;
         rrts_pkg::S_TICK_SLICE: state_in = rrts_pkg::S_TICK_OUT;
         rrts_pkg::S_TICK_OUT:   state_in = rrts_pkg::S_DONE;
         rrts_pkg::S_SLP_RD:     state_in = rrts_pkg::S_SLP_CHK;
         rrts_pkg::S_SLP_CHK: begin
            state_in = slp_refuse ? rrts_pkg::S_DONE : rrts_pkg::S_SLP_CUR;
         end
         rrts_pkg::S_SLP_CUR:    state_in = rrts_pkg::S_SLP_FIND;
         rrts_pkg::S_SLP_FIND: begin
            if (find_hit) begin
               state_in = rrts_pkg::S_SLP_SHIFT;
            end
         end
         rrts_pkg::S_SLP_SHIFT: begin
            if (!shift_more) begin
               state_in = rrts_pkg::S_SLP_FIX;
            end
         end
         rrts_pkg::S_SLP_FIX:    state_in = rrts_pkg::S_SLP_LAST;
         rrts_pkg::S_SLP_LAST:   state_in = rrts_pkg::S_SLP_OUT;
         rrts_pkg::S_SLP_OUT:    state_in = rrts_pkg::S_DONE;
         rrts_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = rrts_pkg::S_IDLE;
            end
         end
         default: state_in = rrts_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      scan_in       = scan_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      chk_in        = chk_ff;
      rc_in         = rc_ff;
      ci_in         = ci_ff;
      slice0_in     = slice0_ff;
      id_in         = id_ff;
      slice_in      = slice_ff;
      was_in        = was_ff;
      tmp_in        = tmp_ff;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      res_reload_in = res_reload_ff;
      res_switch_in = res_switch_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_reload_in = rsp_reload_ff;
      rsp_switch_in = rsp_switch_ff;

      st_wr_en   = 1'b0;
      st_wr_addr = slot_id;
      st_wr_data = rrts_pkg::SLOT_ALLOC;
      st_rd_addr = slot_id;
      sl_wr_en   = 1'b0;
      sl_wr_addr = slot_id;
      sl_wr_data = slice_ff;
      sl_rd_addr = ls_rd;
      ls_wr_en   = 1'b0;
      ls_wr_addr = AW'(rc_ff);
      ls_wr_data = slot_id;
      ls_rd_addr = ci_ff;

      if (csr_wr_en) begin
         slice0_in = csr_wr_data;
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rrts_pkg::S_CLEAR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = scan_ff[AW-1:0];
            st_wr_data = (scan_ff == '0) ? rrts_pkg::SLOT_RUN : rrts_pkg::SLOT_FREE;
            sl_wr_en   = 1'b1;
            sl_wr_addr = scan_ff[AW-1:0];
            sl_wr_data = '0;
            ls_wr_en   = (scan_ff == '0);
            ls_wr_addr = '0;
            ls_wr_data = '0;
            scan_in    = scan_ff + IW'(1);
         end
         rrts_pkg::S_IDLE: begin
            id_in         = req.task_id;
            slice_in      = req.slice_ticks;
            scan_in       = '0;
            chk_in        = 1'b0;
            // Only run and sleep address a slot, so only they can name one out of range.
            res_status_in = (in_id_ok || (req.req_type == rrts_pkg::REQ_ALLOC) ||
                             (req.req_type == rrts_pkg::REQ_TICK)) ?
                            rrts_pkg::STATUS_DONE : rrts_pkg::STATUS_IGNORED;
            res_task_in   = '0;
            res_reload_in = '0;
            res_switch_in = 1'b0;
         end
         rrts_pkg::S_ALLOC: begin
            // Reads run one slot ahead of the compare.
            st_rd_addr = scan_ff[AW-1:0];
            scan_in    = scan_ff + IW'(1);
            prev_in    = scan_ff;
            chk_in     = 1'b1;
            if (alloc_hit) begin
               st_wr_en      = 1'b1;
               st_wr_addr    = prev_ff[AW-1:0];
               st_wr_data    = rrts_pkg::SLOT_ALLOC;
               res_task_in   = rrts_pkg::TASK_ID_W'(prev_ff);
            end else if (alloc_end) begin
               res_status_in = rrts_pkg::STATUS_NO_SLOT;
            end
         end
         rrts_pkg::S_RUN_EXEC: begin
            if (st_rd == rrts_pkg::SLOT_FREE) begin
               res_status_in = rrts_pkg::STATUS_IGNORED;
            end else begin
               if (slice_ff != '0) begin
                  if (slot_id == '0) begin
                     slice0_in = slice_ff;
                  end else begin
                     sl_wr_en = 1'b1;
                  end
               end
               if ((st_rd != rrts_pkg::SLOT_RUN) && (rc_ext < IW'(TASK_SLOTS))) begin
                  st_wr_en   = 1'b1;
                  st_wr_data = rrts_pkg::SLOT_RUN;
                  ls_wr_en   = 1'b1;
                  rc_in      = rc_ff + CW'(1);
               end
            end
         end
         rrts_pkg::S_TICK: begin
            ci_in = (ci_inc >= rc_ext) ? '0 : ci_inc[AW-1:0];
         end
         rrts_pkg::S_TICK_SLICE: begin
            tmp_in = ls_rd;
         end
         rrts_pkg::S_TICK_OUT: begin
            res_task_in   = rrts_pkg::TASK_ID_W'(tmp_ff);
            res_reload_in = (tmp_ff == '0) ? slice0_ff : sl_rd;
            res_switch_in = (rc_ff >= CW'(2));
         end
         rrts_pkg::S_SLP_CHK: begin
            if (slp_refuse) begin
               res_status_in = rrts_pkg::STATUS_IGNORED;
            end
         end
         rrts_pkg::S_SLP_CUR: begin
            was_in  = (ls_rd == slot_id);
            scan_in = '0;
            chk_in  = 1'b0;
         end
         rrts_pkg::S_SLP_FIND: begin
            ls_rd_addr = scan_ff[AW-1:0];
            scan_in    = scan_ff + IW'(1);
            chk_in     = 1'b1;
            if (find_hit) begin
               // The entry after the hit is being read now; prev becomes the write pointer.
               pos_in  = prev_ff;
               prev_in = prev_ff;
            end else begin
               prev_in = scan_ff;
            end
         end
         rrts_pkg::S_SLP_SHIFT: begin
            ls_rd_addr = scan_ff[AW-1:0];
            if (shift_more) begin
               ls_wr_en   = 1'b1;
               ls_wr_addr = prev_ff[AW-1:0];
               ls_wr_data = ls_rd;
               prev_in    = prev_ff + IW'(1);
               scan_in    = scan_ff + IW'(1);
            end
         end
         rrts_pkg::S_SLP_FIX: begin
            rc_in      = rc_dec;
            ci_in      = (IW'(ci_adj) >= IW'(rc_dec)) ? '0 : ci_adj;
            st_wr_en   = 1'b1;
            st_wr_data = rrts_pkg::SLOT_ALLOC;
         end
         rrts_pkg::S_SLP_OUT: begin
            res_task_in   = rrts_pkg::TASK_ID_W'(ls_rd);
            res_switch_in = was_ff;
         end
         rrts_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_task_in   = res_task_ff;
               rsp_reload_in = res_reload_ff;
               rsp_switch_in = res_switch_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::S_CLEAR;
         scan_ff      <= '0;
         chk_ff       <= 1'b0;
         rc_ff        <= CW'(1);
         ci_ff        <= '0;
         slice0_ff    <= rrts_pkg::INIT_SLICE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         chk_ff       <= chk_in;
         rc_ff        <= rc_in;
         ci_ff        <= ci_in;
         slice0_ff    <= slice0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff       <= prev_in;
      pos_ff        <= pos_in;
      id_ff         <= id_in;
      slice_ff      <= slice_in;
      was_ff        <= was_in;
      tmp_ff        <= tmp_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      res_reload_ff <= res_reload_in;
      res_switch_ff <= res_switch_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_switch_ff <= rsp_switch_in;
   end

   rrts_ram #(
      .WIDTH (rrts_pkg::SLOT_ST_W),
      .DEPTH (TASK_SLOTS)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd)
   );

   rrts_ram #(
      .WIDTH (rrts_pkg::SLICE_W),
      .DEPTH (TASK_SLOTS)
   ) u_slice_ram (
      .clock   (clock),
      .wr_en   (sl_wr_en),
      .wr_addr (sl_wr_addr),
      .wr_data (sl_wr_data),
      .rd_addr (sl_rd_addr),
      .rd_data (sl_rd)
   );

   rrts_ram #(
      .WIDTH (AW),
      .DEPTH (TASK_SLOTS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (ls_wr_addr),
      .wr_data (ls_wr_data),
      .rd_addr (ls_rd_addr),
      .rd_data (ls_rd)
   );

   assign req.ready        = (state_ff == rrts_pkg::S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_task  = rsp_task_ff;
   assign rsp.timer_reload = rsp_reload_ff;
   assign rsp.do_switch    = rsp_switch_ff;

   // The current index always points inside the run list.
   a_index_in_list: assert property (@(posedge clock) disable iff (reset)
      IW'(ci_ff) < rc_ext)
      else $error("current index beyond run list");

   // At least one task runs and the list never overflows.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (rc_ff != '0) && (rc_ext <= IW'(TASK_SLOTS)))
      else $error("run count out of range");

   // A completed sleep removes exactly one entry from the run list.
   a_sleep_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrts_pkg::S_SLP_FIX) |=> (rc_ff == CW'($past(rc_ff) - CW'(1))))
      else $error("sleep did not shrink the run list by one");

   // Leaving the final state always leaves a response beat pending.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrts_pkg::S_DONE) && rsp_free |=> rsp_valid_ff)
      else $error("response beat lost");

endmodule

// ===== tb/sv/round_robin_task_scheduler_tb.sv =====
// Self-checking testbench of the round-robin task scheduler: directed table, then random requests.
module round_robin_task_scheduler_tb;
   import rrts_pkg::*;

   localparam int SLOTS         = TASK_SLOTS_DEFAULT;
   localparam int PHASE_ITEMS   = 256;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 100;
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int LIMIT_CYCLES  = 600000;
   localparam bit TYPED         = 1'b1;
   localparam bit PREDICTED     = 1'b0;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [TASK_ID_W-1:0]  task_id;
      logic [SLICE_W-1:0]    slice;
   } sched_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [TASK_ID_W-1:0] result_task;
      logic [SLICE_W-1:0]   timer_reload;
      logic                 do_switch;
   } sched_rsp_type;

   typedef struct packed {
      sched_req_type rq;
      logic          typed;
      sched_rsp_type rs;
   } sched_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [SLICE_W-1:0] csr_wr_data;

   rrts_req_if req_ch ();
   rrts_rsp_if rsp_ch ();

   round_robin_task_scheduler #(.TASK_SLOTS(SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Scheduler state as the testbench expects it.
   logic [SLOT_ST_W-1:0] slot_st   [SLOTS];
   logic [SLICE_W-1:0]   slice_mem [SLOTS];
   logic [TASK_ID_W-1:0] run_order [SLOTS];
   int                   run_cnt;
   int                   cur_idx;
   int                   alloc_top;

   sched_rsp_type rsp_pending [$];
   int            mismatches;
   int            rsp_beats;
   int            burst_left;
   int            cycle_count;

   // Expected values are typed in only where they follow at a glance from the reset state.
   sched_row_type dir_rows [25] = '{
      '{'{REQ_TICK,  6'd0,  16'h0000}, TYPED,     '{STATUS_DONE,    6'd0, 16'd2, 1'b0}},
      '{'{REQ_SLEEP, 6'd0,  16'h0000}, TYPED,     '{STATUS_IGNORED, 6'd0, 16'd0, 1'b0}},
      '{'{REQ_SLEEP, 6'd5,  16'h0000}, TYPED,     '{STATUS_IGNORED, 6'd0, 16'd0, 1'b0}},
      '{'{REQ_RUN,   6'd7,  16'h1234}, TYPED,     '{STATUS_IGNORED, 6'd0, 16'd0, 1'b0}},
      '{'{REQ_ALLOC, 6'd0,  16'h0000}, TYPED,     '{STATUS_DONE,    6'd1, 16'd0, 1'b0}},
      '{'{REQ_ALLOC, 6'd63, 16'hFFFF}, TYPED,     '{STATUS_DONE,    6'd2, 16'd0, 1'b0}},
      '{'{REQ_RUN,   6'd1,  16'hFFFF}, TYPED,     '{STATUS_DONE,    6'd0, 16'd0, 1'b0}},
      '{'{REQ_RUN,   6'd2,  16'h0000}, TYPED,     '{STATUS_DONE,    6'd0, 16'd0, 1'b0}},
      '{'{REQ_RUN,   6'd1,  16'h0001}, TYPED,     '{STATUS_DONE,    6'd0, 16'd0, 1'b0}},
      '{'{REQ_TICK,  6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_TICK,  6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_SLEEP, 6'd1,  16'h0000}, PREDICTED, '0},
      '{'{REQ_SLEEP, 6'd2,  16'h0000}, PREDICTED, '0},
      '{'{REQ_SLEEP, 6'd0,  16'h0000}, TYPED,     '{STATUS_IGNORED, 6'd0, 16'd0, 1'b0}},
      '{'{REQ_RUN,   6'd0,  16'h0000}, TYPED,     '{STATUS_DONE,    6'd0, 16'd0, 1'b0}},
      '{'{REQ_ALLOC, 6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_RUN,   6'd3,  16'hFFFF}, PREDICTED, '0},
      '{'{REQ_ALLOC, 6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_RUN,   6'd4,  16'h0100}, PREDICTED, '0},
      '{'{REQ_TICK,  6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_TICK,  6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_TICK,  6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_SLEEP, 6'd0,  16'h0000}, PREDICTED, '0},
      '{'{REQ_RUN,   6'd63, 16'h0000}, TYPED,     '{STATUS_IGNORED, 6'd0, 16'd0, 1'b0}},
      '{'{REQ_SLEEP, 6'd63, 16'hFFFF}, TYPED,     '{STATUS_IGNORED, 6'd0, 16'd0, 1'b0}}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void reset_schedule();
      for (int i = 0; i < SLOTS; i++) begin
         slot_st[i]   = SLOT_FREE;
         slice_mem[i] = '0;
         run_order[i] = '0;
      end
      slot_st[0]   = SLOT_RUN;
      slice_mem[0] = INIT_SLICE_RESET;
      run_cnt      = 1;
      cur_idx      = 0;
      alloc_top    = 0;
   endfunction

   // Applies one request to the expected state and returns its response.
   function automatic sched_rsp_type schedule_request(sched_req_type rq);
      sched_rsp_type r;
      int            pos;
      bit            was_cur;
      r = '0;
      case (rq.kind)
         REQ_ALLOC: begin
            r.status = STATUS_NO_SLOT;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_st[i] == SLOT_FREE) begin
                  slot_st[i]    = SLOT_ALLOC;
                  alloc_top     = i;
                  r.status      = STATUS_DONE;
                  r.result_task = TASK_ID_W'(i);
                  break;
               end
            end
         end
         REQ_TICK: begin
            cur_idx++;
            if (cur_idx >= run_cnt) cur_idx = 0;
            r.status       = STATUS_DONE;
            r.result_task  = run_order[cur_idx];
            r.timer_reload = slice_mem[run_order[cur_idx]];
            r.do_switch    = (run_cnt >= 2);
         end
         REQ_RUN: begin
            if (slot_st[rq.task_id] == SLOT_FREE) begin
               r.status = STATUS_IGNORED;
            end else begin
               if (rq.slice != '0) slice_mem[rq.task_id] = rq.slice;
               if (slot_st[rq.task_id] != SLOT_RUN && run_cnt < SLOTS) begin
                  slot_st[rq.task_id] = SLOT_RUN;
                  run_order[run_cnt]  = rq.task_id;
                  run_cnt++;
               end
               r.status = STATUS_DONE;
            end
         end
         default: begin
            if (slot_st[rq.task_id] != SLOT_RUN || run_cnt <= 1) begin
               r.status = STATUS_IGNORED;
            end else begin
               was_cur = (run_order[cur_idx] == rq.task_id);
               pos = 0;
               while (pos < run_cnt && run_order[pos] != rq.task_id) pos++;
               if (pos < run_cnt) begin
                  run_cnt--;
                  if (pos < cur_idx) cur_idx--;
                  for (int i = pos; i < run_cnt; i++) run_order[i] = run_order[i + 1];
               end
               slot_st[rq.task_id] = SLOT_ALLOC;
               if (cur_idx >= run_cnt) cur_idx = 0;
               r.status      = STATUS_DONE;
               r.result_task = run_order[cur_idx];
               r.do_switch   = was_cur;
            end
         end
      endcase
      return r;
   endfunction

   // Mostly requests aimed at slots that are in use, some pure noise.
   function automatic sched_req_type pick_request();
      sched_req_type rq;
      int            w;
      int            s;
      rq.kind    = REQ_TYPE_W'($urandom_range(0, 3));
      rq.task_id = TASK_ID_W'($urandom);
      w = $urandom_range(0, 99);
      if (w < 12) begin
         rq.kind = REQ_ALLOC;
      end else if (w < 45) begin
         rq.kind = REQ_RUN;
         if ($urandom_range(0, 3) != 0) rq.task_id = TASK_ID_W'($urandom_range(0, alloc_top));
      end else if (w < 67) begin
         rq.kind = REQ_SLEEP;
         if ($urandom_range(0, 3) != 0)
            rq.task_id = run_order[$urandom_range(0, run_cnt - 1)];
      end else if (w < 95) begin
         rq.kind = REQ_TICK;
      end
      s = $urandom_range(0, 9);
      if (s < 2) rq.slice = '0;
      else if (s == 2) rq.slice = '1;
      else if (s == 3) rq.slice = SLICE_W'(1);
      else rq.slice = SLICE_W'($urandom);
      return rq;
   endfunction

   task automatic send_request(input sched_req_type rq, input logic typed,
                               input sched_rsp_type rs);
      int gap;
      sched_rsp_type pred;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= rq.kind;
      req_ch.task_id     <= rq.task_id;
      req_ch.slice_ticks <= rq.slice;
      do @(posedge clock); while (!req_ch.ready);
      pred = schedule_request(rq);
      rsp_pending.push_back(typed ? rs : pred);
   endtask

   // Stops offering beats and waits until every response is back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (rsp_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_initial_slice(input logic [SLICE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      slice_mem[0] = value;
   endtask

   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_beats
      sched_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_beats++;
         if (rsp_pending.size() == 0) begin
            $display("%0t: unexpected response beat, status %0d task %0d", $time,
                     rsp_ch.status, rsp_ch.result_task);
            mismatches++;
         end else begin
            want = rsp_pending.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
            check_field("result_task", 32'(want.result_task), 32'(rsp_ch.result_task));
            check_field("timer_reload", 32'(want.timer_reload), 32'(rsp_ch.timer_reload));
            check_field("do_switch", 32'(want.do_switch), 32'(rsp_ch.do_switch));
         end
      end
   end

   // Receiver: runs of always-ready, coin-flip and sparse acceptance, plus one long hold-off.
   int  rx_mode;
   int  rx_left;
   int  hold_left;
   bit  hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_left   = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && rsp_beats >= HOLD_AFTER) begin
         rsp_ch.ready <= 1'b0;
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 4);
            rx_left = $urandom_range(8, 80);
         end
         rx_left--;
         case (rx_mode)
            0, 1:    rsp_ch.ready <= 1'b1;
            2, 3:    rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("round_robin_task_scheduler: mismatch");
         $finish;
      end
   end

   initial begin
      logic [SLICE_W-1:0] phase_slice [4];
      phase_slice = '{16'hFFFF, 16'd1, SLICE_W'($urandom_range(3, 65534)),
                      SLICE_W'($urandom_range(3, 65534))};
      mismatches  = 0;
      rsp_beats   = 0;
      burst_left  = 0;
      cycle_count = 0;
      reset_schedule();
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_ALLOC;
      req_ch.task_id     <= '0;
      req_ch.slice_ticks <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);
      drain_responses();

      for (int ph = 0; ph < 4; ph++) begin
         write_initial_slice(phase_slice[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(pick_request(), PREDICTED, '0);
         drain_responses();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("round_robin_task_scheduler: match");
      end else begin
         $display("round_robin_task_scheduler: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rrts_pkg.sv
hdl/rrts_if.sv
hdl/rrts_ram.sv
hdl/round_robin_task_scheduler.sv
tb/sv/round_robin_task_scheduler_tb.sv
